### sv/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants for the WSOLA time stretch block.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

   localparam int unsigned HOP_MAX     = 64;
   localparam int unsigned HOP_W       = 7;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned ACC_W       = 24;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned HOP_RESET   = 32;

   // Register indexes, taken from the word address of the configuration port.
   localparam logic REG_ANALYSIS_HOP  = 1'b0;
   localparam logic REG_SYNTHESIS_HOP = 1'b1;

   // One queue entry: a sample to store and, if frame is set, the hops of
   // the frame that this sample completes.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame;
      logic [HOP_W-1:0]           ha;
      logic [HOP_W-1:0]           hs;
   } wts_cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_CORR,
      BK_DRAIN,
      BK_ADD,
      BK_EMIT_RD,
      BK_EMIT
   } wts_back_state_type;

   // Hop register value as used by the datapath: zero acts as one, large
   // values saturate.
   function automatic logic [HOP_W-1:0] clamp_hop(input logic [HOP_W-1:0] h);
      logic [HOP_W-1:0] r;
      r = h;
      if (h == '0) begin
         r = HOP_W'(1);
      end else if (h > HOP_W'(HOP_MAX)) begin
         r = HOP_W'(HOP_MAX);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/wts_if.sv
// ----------------------------------------------------------------------------
// wts_req_if / wts_rsp_if
// Valid/ready channels for input samples and stretched output samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface wts_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface wts_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;
   logic               last_of_frame;

   modport source (output valid, output sample_out, output last_of_frame, input ready);
   modport sink   (input valid, input sample_out, input last_of_frame, output ready);
endinterface

`default_nettype wire

### sv/wts_front.sv
// ----------------------------------------------------------------------------
// wts_front
// Configuration registers and input classification: counts buffered samples
// and marks the sample that completes a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_front
   import wts_pkg::*;
#(
   parameter int unsigned WINDOW = 128
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wts_req_if.sink                    req_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   input  wire logic                  back_ready,
   input  wire logic                  q_full,
   output logic                       q_push,
   output wts_cmd_type                q_data
);

   localparam int unsigned BW = $clog2(WINDOW + HOP_MAX + 1);

   logic [HOP_W-1:0] ha_ff, ha_in, hs_ff, hs_in;
   logic [BW-1:0]    buf_ff, buf_in;
   logic [BW-1:0]    buf_inc;
   logic [HOP_W-1:0] ha_c, hs_c;
   logic             frame;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_SYNTHESIS_HOP) ?
                   CSR_DATA_W'(hs_ff) : CSR_DATA_W'(ha_ff);

   assign req_ch.ready = back_ready && !q_full;
   assign q_push       = req_ch.valid && req_ch.ready;

   assign ha_c    = clamp_hop(ha_ff);
   assign hs_c    = clamp_hop(hs_ff);
   assign buf_inc = buf_ff + BW'(1);
   assign frame   = buf_inc >= BW'(WINDOW) + BW'(ha_c[HOP_W-1:1]);

   always_comb begin
      q_data.sample = req_ch.sample_in;
      q_data.frame  = frame;
      q_data.ha     = ha_c;
      q_data.hs     = hs_c;
   end

   always_comb begin
      ha_in  = ha_ff;
      hs_in  = hs_ff;
      buf_in = buf_ff;
      if (csr_wr) begin
         if (paddr[2] == REG_ANALYSIS_HOP) begin
            ha_in = pwdata[HOP_W-1:0];
         end else begin
            hs_in = pwdata[HOP_W-1:0];
         end
      end
      if (q_push) begin
         buf_in = frame ? (buf_inc - BW'(ha_c)) : buf_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ha_ff  <= HOP_W'(HOP_RESET);
         hs_ff  <= HOP_W'(HOP_RESET);
         buf_ff <= '0;
      end else begin
         ha_ff  <= ha_in;
         hs_ff  <= hs_in;
         buf_ff <= buf_in;
      end
   end

endmodule

`default_nettype wire

### sv/wts_queue.sv
// ----------------------------------------------------------------------------
// wts_queue
// Two-entry queue of sample commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_queue
   import wts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire wts_cmd_type push_data,
   output logic             full,
   input  wire logic        pop,
   output wts_cmd_type      pop_data,
   output logic             empty
);

   wts_cmd_type mem_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop  ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### sv/wts_back.sv
// ----------------------------------------------------------------------------
// wts_back
// History ring, lag search, Hann-weighted overlap-add and output sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_back
   import wts_pkg::*;
#(
   parameter int unsigned WINDOW        = 128,
   parameter int unsigned HISTORY_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  wire wts_cmd_type q_data,
   output logic             q_pop,
   output logic             back_ready,
   wts_rsp_if.source        rsp_ch
);

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);
   localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
   localparam int unsigned WW = $clog2(WINDOW);
   localparam int unsigned CW = 2 * SAMPLE_W + WW + 1;
   localparam int unsigned RW = WW + 1;
   localparam int unsigned HQ = 65536 / (WINDOW - 1);
   localparam int unsigned HR = 65536 % (WINDOW - 1);
   localparam logic [2:0]  STEP_LAST = 3'd6;

   wts_back_state_type state_ff, state_in;

   // Memories
   logic signed [SAMPLE_W-1:0] ring_mem [HISTORY_DEPTH];
   logic signed [ACC_W-1:0]    acc_mem  [WINDOW];
   logic signed [SAMPLE_W-1:0] ring_a_q, ring_b_q;
   logic signed [ACC_W-1:0]    acc_q;

   // Frame bookkeeping
   logic [AW-1:0]    wr_ptr_ff, rp_ff, lag_ptr_ff, best_ptr_ff, a_ptr_ff, b_ptr_ff;
   logic [FW-1:0]    fill_ff;
   logic [WW-1:0]    base_ff, acc_ptr_ff, clr_ff, i_ff;
   logic [HOP_W-1:0] ha_ff, hs_ff, lag_cnt_ff, k_ff;
   logic [5:0]       r_ff;
   logic             first_ff;

   // Correlation pipeline
   logic                 ma_ff, mb_ff, v1_ff, last1_ff, v2_ff, last2_ff;
   logic signed [31:0]   cprod_ff;
   logic signed [CW-1:0] corr_ff, best_ff, corr_final;
   logic signed [SAMPLE_W-1:0] a_m, b_m;

   // Hann / overlap-add steps
   logic [2:0]                step_ff;
   logic [16:0]               q_ff;
   logic [RW-1:0]             rem_ff, rem_sum;
   logic [16:0]               y_ff, s_ff;
   logic [15:0]               t_ff, w_ff;
   logic signed [32:0]        p_ff;
   logic [34:0]               y_prod;
   logic [31:0]               t_prod;
   logic [33:0]               s_prod, w_prod;
   logic signed [33:0]        p_round;
   logic signed [ACC_W+1:0]   acc_sum;
   logic signed [ACC_W-1:0]   acc_sat;
   logic signed [SAMPLE_W-1:0] out_sat;

   // Output register
   logic                       out_v_ff;
   logic signed [SAMPLE_W-1:0] out_d_ff;
   logic                       out_l_ff;

   // Control
   logic             issue, out_load, acc_we;
   logic [WW-1:0]    acc_wa;
   logic signed [ACC_W-1:0] acc_wd;
   logic [AW-1:0]    a_addr;
   logic [AW:0]      lag_start;
   logic [5:0]       r_new;

   function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
      return (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [WW-1:0] inc_acc(input logic [WW-1:0] p);
      return (p == WW'(WINDOW - 1)) ? '0 : p + WW'(1);
   endfunction

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == WW'(WINDOW - 1)) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (!q_empty && q_data.frame) state_in = BK_CORR;
         end
         BK_CORR: begin
            if (i_ff == WW'(WINDOW - 1)) state_in = BK_DRAIN;
         end
         BK_DRAIN: begin
            if (v2_ff && last2_ff) begin
               state_in = (lag_cnt_ff == {r_ff, 1'b0}) ? BK_ADD : BK_CORR;
            end
         end
         BK_ADD: begin
            if (step_ff == STEP_LAST && i_ff == WW'(WINDOW - 1)) state_in = BK_EMIT_RD;
         end
         BK_EMIT_RD: state_in = BK_EMIT;
         BK_EMIT: begin
            if (out_load) state_in = (k_ff == hs_ff - HOP_W'(1)) ? BK_IDLE : BK_EMIT_RD;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // ---------------- outputs ----------------
   always_comb begin
      q_pop      = (state_ff == BK_IDLE) && !q_empty;
      back_ready = state_ff != BK_CLEAR;
      issue      = state_ff == BK_CORR;
      out_load   = (state_ff == BK_EMIT) && (!out_v_ff || rsp_ch.ready);
      a_addr     = a_ptr_ff;
      acc_we     = 1'b0;
      acc_wa     = acc_ptr_ff;
      acc_wd     = acc_sat;
      case (state_ff)
         BK_CLEAR: begin
            acc_we = 1'b1;
            acc_wa = clr_ff;
            acc_wd = '0;
         end
         BK_ADD: acc_we = step_ff == STEP_LAST;
         BK_EMIT: begin
            acc_we = out_load;
            acc_wd = '0;
         end
         default: acc_we = 1'b0;
      endcase
   end

   // ---------------- datapath arithmetic ----------------
   assign a_m = ma_ff ? ring_a_q : '0;
   assign b_m = mb_ff ? ring_b_q : '0;
   assign corr_final = corr_ff + CW'(cprod_ff);

   assign r_new     = q_data.ha[HOP_W-1:1];
   assign lag_start = ({1'b0, rp_ff} >= (AW + 1)'(r_new)) ?
                      {1'b0, rp_ff} - (AW + 1)'(r_new) :
                      {1'b0, rp_ff} + (AW + 1)'(HISTORY_DEPTH) - (AW + 1)'(r_new);

   assign y_prod  = {1'b0, q_ff[15:0], 2'b00} * {18'b0, 17'h10000 - {1'b0, q_ff[15:0]}};
   assign t_prod  = 32'(y_ff) * 32'd14746;
   assign s_prod  = 34'(y_ff) * 34'(17'd50790 + {1'b0, t_ff});
   assign w_prod  = 34'(s_ff) * 34'(s_ff) + 34'd65536;
   assign p_round = 34'(p_ff) + 34'sd16384;
   assign rem_sum = rem_ff + RW'(HR);
   assign acc_sum = (ACC_W + 2)'(acc_q) + (ACC_W + 2)'($signed(p_round[33:15]));

   always_comb begin
      if (acc_sum > (ACC_W + 2)'(26'sd8388607)) begin
         acc_sat = 24'sh7FFFFF;
      end else if (acc_sum < -(ACC_W + 2)'(26'sd8388608)) begin
         acc_sat = 24'sh800000;
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
      if (acc_q > 24'sd32767) begin
         out_sat = 16'sh7FFF;
      end else if (acc_q < -24'sd32768) begin
         out_sat = 16'sh8000;
      end else begin
         out_sat = acc_q[SAMPLE_W-1:0];
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ring_mem[wr_ptr_ff] <= q_data.sample;
      end
      ring_a_q <= ring_mem[a_addr];
      ring_b_q <= ring_mem[b_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
      acc_q <= acc_mem[acc_ptr_ff];
   end

   // ---------------- correlation pipeline ----------------
   always_ff @(posedge clock) begin
      ma_ff    <= {1'b0, a_addr} < fill_ff;
      mb_ff    <= {1'b0, b_ptr_ff} < fill_ff;
      cprod_ff <= a_m * b_m;
      if (reset) begin
         v1_ff    <= 1'b0;
         last1_ff <= 1'b0;
         v2_ff    <= 1'b0;
         last2_ff <= 1'b0;
         corr_ff  <= '0;
      end else begin
         v1_ff    <= issue;
         last1_ff <= issue && (i_ff == WW'(WINDOW - 1));
         v2_ff    <= v1_ff;
         last2_ff <= last1_ff;
         if (v2_ff) begin
            corr_ff <= last2_ff ? '0 : corr_final;
         end
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
         wr_ptr_ff <= '0;
         rp_ff    <= '0;
         fill_ff  <= '0;
         base_ff  <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            BK_CLEAR: clr_ff <= clr_ff + WW'(1);
            BK_IDLE: begin
               if (q_pop) begin
                  wr_ptr_ff <= inc_ptr(wr_ptr_ff);
                  if (fill_ff != FW'(HISTORY_DEPTH)) fill_ff <= fill_ff + FW'(1);
               end
            end
            BK_EMIT: begin
               if (out_load && k_ff == hs_ff - HOP_W'(1)) begin
                  base_ff <= ({1'b0, base_ff} + (WW + 1)'(hs_ff) >= (WW + 1)'(WINDOW)) ?
                             WW'({1'b0, base_ff} + (WW + 1)'(hs_ff) - (WW + 1)'(WINDOW)) :
                             base_ff + WW'(hs_ff);
                  rp_ff   <= ({1'b0, rp_ff} + (AW + 1)'(ha_ff) >= (AW + 1)'(HISTORY_DEPTH)) ?
                             AW'({1'b0, rp_ff} + (AW + 1)'(ha_ff) - (AW + 1)'(HISTORY_DEPTH)) :
                             rp_ff + AW'(ha_ff);
               end
            end
            default: clr_ff <= clr_ff;
         endcase
      end
   end

   // Frame datapath registers; control above gates when they matter.
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (q_pop && q_data.frame) begin
               ha_ff      <= q_data.ha;
               hs_ff      <= q_data.hs;
               r_ff       <= r_new;
               lag_ptr_ff <= AW'(lag_start);
               a_ptr_ff   <= AW'(lag_start);
               b_ptr_ff   <= rp_ff;
               i_ff       <= '0;
               lag_cnt_ff <= '0;
               first_ff   <= 1'b1;
            end
         end
         BK_CORR: begin
            a_ptr_ff <= inc_ptr(a_ptr_ff);
            b_ptr_ff <= inc_ptr(b_ptr_ff);
            i_ff     <= i_ff + WW'(1);
         end
         BK_DRAIN: begin
            if (v2_ff && last2_ff) begin
               if (first_ff || corr_final > best_ff) begin
                  best_ff     <= corr_final;
                  best_ptr_ff <= lag_ptr_ff;
               end
               first_ff <= 1'b0;
               if (lag_cnt_ff == {r_ff, 1'b0}) begin
                  // Search done: set up the overlap-add sweep on the winner.
                  a_ptr_ff   <= (first_ff || corr_final > best_ff) ? lag_ptr_ff : best_ptr_ff;
                  acc_ptr_ff <= base_ff;
                  i_ff       <= '0;
                  step_ff    <= '0;
                  q_ff       <= '0;
                  rem_ff     <= '0;
               end else begin
                  lag_ptr_ff <= inc_ptr(lag_ptr_ff);
                  a_ptr_ff   <= inc_ptr(lag_ptr_ff);
                  b_ptr_ff   <= rp_ff;
                  i_ff       <= '0;
                  lag_cnt_ff <= lag_cnt_ff + HOP_W'(1);
               end
            end
         end
         BK_ADD: begin
            step_ff <= (step_ff == STEP_LAST) ? 3'd0 : step_ff + 3'd1;
            case (step_ff)
               3'd1: y_ff <= y_prod[32:16];
               3'd2: t_ff <= t_prod[31:16];
               3'd3: s_ff <= s_prod[32:16];
               3'd4: w_ff <= w_prod[32:17];
               3'd5: p_ff <= a_m * $signed({1'b0, w_ff});
               STEP_LAST: begin
                  a_ptr_ff   <= inc_ptr(a_ptr_ff);
                  i_ff       <= i_ff + WW'(1);
                  // Hann phase advances by 65536/(WINDOW-1) per sample.
                  if (rem_sum >= RW'(WINDOW - 1)) begin
                     rem_ff <= rem_sum - RW'(WINDOW - 1);
                     q_ff   <= q_ff + 17'(HQ + 1);
                  end else begin
                     rem_ff <= rem_sum;
                     q_ff   <= q_ff + 17'(HQ);
                  end
                  if (i_ff == WW'(WINDOW - 1)) begin
                     acc_ptr_ff <= base_ff;
                     k_ff       <= '0;
                  end else begin
                     acc_ptr_ff <= inc_acc(acc_ptr_ff);
                  end
               end
               default: y_ff <= y_ff;
            endcase
         end
         BK_EMIT: begin
            if (out_load) begin
               out_d_ff   <= out_sat;
               out_l_ff   <= k_ff == hs_ff - HOP_W'(1);
               acc_ptr_ff <= inc_acc(acc_ptr_ff);
               k_ff       <= k_ff + HOP_W'(1);
            end
         end
         default: i_ff <= i_ff;
      endcase
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.sample_out    = out_d_ff;
   assign rsp_ch.last_of_frame = out_l_ff;

endmodule

`default_nettype wire

### sv/wsola_time_stretch.sv
// ----------------------------------------------------------------------------
// wsola_time_stretch
// WSOLA time-scale modification of a 16-bit audio stream.
// ----------------------------------------------------------------------------
// A sample that does not complete a frame is only stored in the history
// memory. A sample that completes a frame starts the lag search over
// 2*(analysis_hop/2)+1 lags, which runs one multiply-accumulate per cycle on
// a two-port history memory while a lag is correlated, with a pipeline
// drain between lags; then Hann-weighted overlap-add on the accumulator
// memory, then the emission of synthesis_hop samples, each read from the
// accumulator before it is loaded into the output register. A two-entry
// queue lets samples be taken while a frame is in progress. After reset the
// accumulator is cleared, and no sample is taken until that is done;
// configuration writes are taken at any time and apply from the next frame.
`default_nettype none

module wsola_time_stretch
   import wts_pkg::*;
#(
   parameter int unsigned WINDOW        = 128,
   parameter int unsigned HISTORY_DEPTH = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wts_req_if.sink                    req_ch,
   wts_rsp_if.source                  rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic        back_ready, q_full, q_push, q_pop, q_empty;
   wts_cmd_type q_in, q_out;

   wts_front #(.WINDOW(WINDOW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .back_ready (back_ready),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   wts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   wts_back #(.WINDOW(WINDOW), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_out),
      .q_pop      (q_pop),
      .back_ready (back_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the WSOLA time stretch block. Random and directed
// samples go in through a valid/ready channel under bursty traffic. The output
// side stalls at random and once holds off for a long stretch. A scoreboard
// predicts every output sample and compares it with what the block emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class wts_scoreboard;
   typedef struct {
      logic signed [15:0] sample;
      logic               last;
   } out_sample_type;

   int          history [256];
   int          overlap [128];
   int unsigned rd_pos;
   int unsigned buffered;
   int unsigned hop_a_reg;
   int unsigned hop_s_reg;
   out_sample_type expected_q[$];
   int          mismatches;

   function new();
      foreach (history[i]) history[i] = 0;
      foreach (overlap[i]) overlap[i] = 0;
      rd_pos    = 0;
      buffered  = 0;
      hop_a_reg = 32;
      hop_s_reg = 32;
      mismatches = 0;
   endfunction

   function void write_reg(logic idx, logic [31:0] value);
      if (idx == wts_pkg::REG_ANALYSIS_HOP) begin
         hop_a_reg = value & 32'h7f;
      end else begin
         hop_s_reg = value & 32'h7f;
      end
   endfunction

   function int unsigned eff_hop(int unsigned h);
      if (h == 0) return 1;
      if (h > 64) return 64;
      return h;
   endfunction

   function longint hist_at(int off);
      return longint'(history[(int'(rd_pos) + 256 + off) % 256]);
   endfunction

   function longint hann_weight(int i);
      longint unsigned u, y, s;
      u = ((longint'(i) * 65536) / 127) & 64'hffff;
      y = (4 * u * (65536 - u)) >> 16;
      s = (y * (50790 + ((14746 * y) >> 16))) >> 16;
      return longint'((s * s + 65536) >> 17);
   endfunction

   // Accept one input sample; runs a frame when enough history is buffered.
   function void note_sample(logic signed [15:0] smp);
      int unsigned ha, hs, r;
      int          best_lag;
      longint      best, corr, a;
      out_sample_type o;
      history[(rd_pos + buffered) % 256] = smp;
      buffered++;
      ha = eff_hop(hop_a_reg);
      hs = eff_hop(hop_s_reg);
      r  = ha / 2;
      if (buffered < 128 + r) return;
      best_lag = -int'(r);
      best = 0;
      for (int lag = -int'(r); lag <= int'(r); lag++) begin
         corr = 0;
         for (int i = 0; i < 128; i++) corr += hist_at(lag + i) * hist_at(i);
         if (lag == -int'(r) || corr > best) begin
            best = corr;
            best_lag = lag;
         end
      end
      for (int i = 0; i < 128; i++) begin
         // Round half up to Q15: the arithmetic shift floors.
         a = longint'(overlap[i]) + ((hist_at(best_lag + i) * hann_weight(i) + 16384) >>> 15);
         if (a > 8388607) a = 8388607;
         if (a < -8388608) a = -8388608;
         overlap[i] = int'(a);
      end
      for (int k = 0; k < int'(hs); k++) begin
         a = overlap[k];
         if (a > 32767) a = 32767;
         if (a < -32768) a = -32768;
         o.sample = a[15:0];
         o.last   = (k == int'(hs) - 1);
         expected_q.push_back(o);
      end
      for (int i = 0; i < 128; i++) begin
         overlap[i] = (i + int'(hs) < 128) ? overlap[i + hs] : 0;
      end
      rd_pos = (rd_pos + ha) % 256;
      buffered -= ha;
   endfunction

   function void check_result(logic signed [15:0] smp, logic last);
      out_sample_type o;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected output sample %0d last %0b", smp, last);
         end
         return;
      end
      o = expected_q.pop_front();
      if (smp !== o.sample || last !== o.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("output mismatch: expected %0d last %0b, got %0d last %0b",
                     o.sample, o.last, smp, last);
         end
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb_top;
   import wts_pkg::*;

   localparam int IDLE_LIMIT = 40000;
   localparam int LONG_HOLD  = 2500;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   wts_req_if req_ch ();
   wts_rsp_if rsp_ch ();

   wts_scoreboard stretch_sb;
   logic hold_req;
   int   idle_cycles;
   int   burst_left;

   wsola_time_stretch dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #10 clock = ~clock;

   // Both channels are observed at the same edge; outputs are checked first.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            stretch_sb.check_result(rsp_ch.sample_out, rsp_ch.last_of_frame);
         end
         if (req_ch.valid && req_ch.ready) begin
            stretch_sb.note_sample(req_ch.sample_in);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("wsola_time_stretch regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Output side: alternates between always ready, random stalls and a
   // periodic pattern, with a long hold-off on request.
   initial begin
      int mode, period, duty, cnt;
      mode = 0;
      period = 5;
      duty = 3;
      cnt = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req = 1'b0;
         end
         cnt++;
         if (cnt % 300 == 0) begin
            mode = $urandom_range(0, 2);
            period = $urandom_range(2, 9);
            duty = $urandom_range(1, period - 1);
         end
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 99) < 55);
            default: rsp_ch.ready <= ((cnt % period) < duty);
         endcase
      end
   end

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      stretch_sb.write_reg(idx, value);
   endtask

   // Offers one sample and returns once the transfer has taken place.
   task automatic send_sample(input logic signed [15:0] smp);
      if (burst_left == 0) begin
         int gap;
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= smp;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic random_samples(input int n);
      int kind;
      for (int j = 0; j < n; j++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            send_sample(16'($urandom_range(0, 65535)));
         end else if (kind < 8) begin
            send_sample(16'(int'($urandom_range(0, 400)) - 200));
         end else if (kind == 8) begin
            send_sample(16'sh7fff);
         end else begin
            send_sample(-16'sh8000);
         end
      end
   endtask

   // The first edge lets the monitor record the last transfer before the
   // outstanding count is looked at.
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (stretch_sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      logic signed [15:0] directed [20];
      stretch_sb = new();
      clock = 1'b0;
      reset = 1'b1;
      hold_req = 1'b0;
      burst_left = 0;
      idle_cycles = 0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.sample_in <= '0;
      rsp_ch.ready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
                   16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh5555,
                   -16'sh5556, 16'sh4000, -16'sh4000, 16'sh00ff, -16'sh0100,
                   16'sh7ffe, -16'sh7fff, 16'sh1234, 16'sh0000, 16'sh7fff};

      // Defaults written explicitly; the first frame sees silence before the
      // stream start on its negative lags.
      csr_write(REG_ANALYSIS_HOP, 32'd32);
      csr_write(REG_SYNTHESIS_HOP, 32'd32);
      foreach (directed[j]) send_sample(directed[j]);
      random_samples(130);
      settle();

      // Once the history has refilled, every sample completes a frame of 64
      // outputs: the long hold-off here fills the block and stalls its input.
      csr_write(REG_ANALYSIS_HOP, 32'd1);
      csr_write(REG_SYNTHESIS_HOP, 32'd64);
      hold_req = 1'b1;
      random_samples(24);
      settle();

      csr_write(REG_ANALYSIS_HOP, 32'd64);
      csr_write(REG_SYNTHESIS_HOP, 32'd1);
      random_samples(70);
      settle();

      // Zero acts as one, values above the maximum saturate; upper bits of
      // the written word are ignored.
      csr_write(REG_ANALYSIS_HOP, 32'hffff_ff80);
      csr_write(REG_SYNTHESIS_HOP, 32'h5a5a_a57f);
      random_samples(30);
      settle();

      csr_write(REG_ANALYSIS_HOP, 32'd127);
      csr_write(REG_SYNTHESIS_HOP, 32'd0);
      random_samples(60);
      settle();

      csr_write(REG_ANALYSIS_HOP, 32'($urandom_range(1, 64)));
      csr_write(REG_SYNTHESIS_HOP, 32'($urandom_range(1, 64)));
      random_samples(50);
      settle();

      repeat (200) @(posedge clock);
      if (stretch_sb.mismatches == 0 && stretch_sb.pending() == 0) begin
         $display("wsola_time_stretch regression: pass");
      end else begin
         $display("wsola_time_stretch regression: fail");
      end
      $finish;
   end
endmodule
